FILE: design/swtct_pkg.sv
// Shared constants, types and helper functions for the sliding window
// time cluster trigger. No dependencies; every other design file imports it.
`default_nettype none

package swtct_pkg;

    // Window storage and timestamp sizing.
    localparam int WINDOW_DEPTH  = 64;
    localparam int TIME_BITS     = 48;
    localparam int IDX_BITS      = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
    localparam int TWICE_BITS    = TIME_BITS + 1;

    // Configuration port and register widths.
    localparam int CFG_BITS      = 32;
    localparam int REG_IDX_BITS  = 2;
    localparam int MIN_HITS_BITS = 7;
    localparam int HITS_BITS     = 7;

    // Widths wide enough for mixed-width compares.
    localparam int THR_BITS = (CNT_BITS > MIN_HITS_BITS) ? CNT_BITS : MIN_HITS_BITS;
    localparam int AGE_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_MIN_HITS      = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DEAD_SPAN     = 2'd2;

    // Result kinds.
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    typedef logic [TIME_BITS-1:0] stamp_t;

    // Commands from the sequencer to the row of window cells.
    typedef struct packed {
        logic eval;   // every cell judges its entry against the new hit
        logic shift;  // the row moves one place, the new hit enters at cell 0
        logic clear;  // all entries become empty
    } chain_ctrl_t;

    // Threshold as used by the decision: zero acts as one, and values above
    // the window depth saturate to the depth.
    function automatic logic [THR_BITS-1:0] eff_threshold(
        input logic [MIN_HITS_BITS-1:0] min_hits
    );
        logic [THR_BITS-1:0] thr;
        begin
            thr = THR_BITS'(min_hits);
            if (thr == '0)
            begin
                thr = THR_BITS'(1);
            end
            else if (thr > THR_BITS'(WINDOW_DEPTH))
            begin
                thr = THR_BITS'(WINDOW_DEPTH);
            end
            return thr;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/swtct_cell.sv
// One window cell: holds one stored hit time and its valid flag.
// Depends on swtct_pkg for widths and the row command struct.
`default_nettype none

module swtct_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire swtct_pkg::chain_ctrl_t        ctrl,
    input  wire swtct_pkg::stamp_t             now,
    input  wire logic [swtct_pkg::CFG_BITS-1:0] window_length,
    input  wire swtct_pkg::stamp_t             in_stamp,
    input  wire logic                          in_valid,
    output swtct_pkg::stamp_t                  stamp,
    output logic                               keep
);
    import swtct_pkg::*;

    stamp_t stamp_reg;
    logic   valid_reg;
    logic   keep_reg;
    stamp_t age;
    logic   in_window;

    // Entries never lie after an in-order new hit, so the difference is the age.
    assign age       = now - stamp_reg;
    assign in_window = AGE_BITS'(age) <= AGE_BITS'(window_length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            keep_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (ctrl.shift)
            begin
                valid_reg <= in_valid;
            end
            if (ctrl.eval)
            begin
                keep_reg <= valid_reg && in_window;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift && !ctrl.clear)
        begin
            stamp_reg <= in_stamp;
        end
    end

    assign stamp = stamp_reg;
    assign keep  = keep_reg;

endmodule

`default_nettype wire

FILE: design/swtct_chain.sv
// Row of window cells, newest at cell 0, plus the edge detect that finds
// the oldest surviving entry. Depends on swtct_pkg and swtct_cell.
`default_nettype none

module swtct_chain (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire swtct_pkg::chain_ctrl_t         ctrl,
    input  wire swtct_pkg::stamp_t              now,
    input  wire logic [swtct_pkg::CFG_BITS-1:0] window_length,
    output logic [swtct_pkg::WINDOW_DEPTH-1:0]  keep,
    output logic [swtct_pkg::CNT_BITS-1:0]      kept_count,
    output swtct_pkg::stamp_t                   oldest_stamp
);
    import swtct_pkg::*;

    stamp_t                  stamp [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] last_kept;

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                swtct_cell u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .ctrl          (ctrl),
                    .now           (now),
                    .window_length (window_length),
                    .in_stamp      (now),
                    .in_valid      (1'b1),
                    .stamp         (stamp[g]),
                    .keep          (keep[g])
                );
            end
            else
            begin : g_body
                swtct_cell u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .ctrl          (ctrl),
                    .now           (now),
                    .window_length (window_length),
                    .in_stamp      (stamp[g-1]),
                    .in_valid      (keep[g-1]),
                    .stamp         (stamp[g]),
                    .keep          (keep[g])
                );
            end
        end
    endgenerate

    // Kept entries form an unbroken run from cell 0, because the stored
    // times are sorted; the last kept cell marks the oldest survivor.
    assign last_kept = keep & ~({1'b0, keep[WINDOW_DEPTH-1:1]});

    always_comb
    begin
        kept_count   = '0;
        oldest_stamp = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (last_kept[i])
            begin
                kept_count   = kept_count | CNT_BITS'(i + 1);
                oldest_stamp = oldest_stamp | stamp[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/sliding_window_time_cluster_trigger_unit.sv
// Sliding window coincidence trigger. Items pass the accept, judge and decide
// steps of the cell row in order, one item at a time; decide loads the result
// into the output register (a hit in dead time ends at judge, with no result).
// A result that is not taken stalls a decide step that has a result to load.
// Reset (rst_n, async, active low) empties the window, clears dead time and loads
// register defaults.
`default_nettype none

module sliding_window_time_cluster_trigger_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Hit input channel.
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [swtct_pkg::TIME_BITS-1:0]      hit_time,
    // Result channel.
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      result_kind,
    output logic [swtct_pkg::TWICE_BITS-1:0]          trigger_time_twice,
    output logic [swtct_pkg::HITS_BITS-1:0]           hits_used,
    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [swtct_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [swtct_pkg::CFG_BITS-1:0]       cfg_data
);
    import swtct_pkg::*;

    // Sequencer states. IDLE waits for a hit, EVAL has every cell judge its
    // entry's age while the order and dead time checks run, DECIDE fires a
    // trigger, reports a dropped hit, or shifts the hit into the window.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]               state_reg, state_next;
    stamp_t                   stamp_reg, stamp_next;
    logic                     ooo_reg, ooo_next;
    stamp_t                   prev_reg, prev_next;
    stamp_t                   last_trig_reg, last_trig_next;
    logic                     dead_reg, dead_next;

    logic [CFG_BITS-1:0]      window_length_reg, window_length_next;
    logic [MIN_HITS_BITS-1:0] min_hits_reg, min_hits_next;
    logic [CFG_BITS-1:0]      dead_span_reg, dead_span_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     kind_reg, kind_next;
    logic [TWICE_BITS-1:0]    twice_reg, twice_next;
    logic [HITS_BITS-1:0]     hits_reg, hits_next;

    chain_ctrl_t              ctrl;
    logic [WINDOW_DEPTH-1:0]  keep;
    logic [CNT_BITS-1:0]      kept_count;
    stamp_t                   chain_oldest;

    logic [THR_BITS-1:0]      thr;
    logic                     fire;
    logic [CNT_BITS-1:0]      used;
    stamp_t                   oldest;
    stamp_t                   since_trigger;
    logic                     in_dead_span;
    logic                     can_load;

    swtct_chain u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .now           (stamp_reg),
        .window_length (window_length_reg),
        .keep          (keep),
        .kept_count    (kept_count),
        .oldest_stamp  (chain_oldest)
    );

    // The window plus the new hit reaches the threshold exactly when the
    // cell at position threshold-2 survived the age check.
    assign thr  = eff_threshold(min_hits_reg);
    assign fire = (thr <= THR_BITS'(1)) ? 1'b1 : keep[IDX_BITS'(thr - THR_BITS'(2))];
    assign used = kept_count + CNT_BITS'(1);

    // With an empty window the new hit is its own oldest entry.
    assign oldest = (kept_count != '0) ? chain_oldest : stamp_reg;

    // An in-order current hit never lies before the last trigger, so this is the
    // time elapsed since it.
    assign since_trigger = stamp_reg - last_trig_reg;
    assign in_dead_span  = AGE_BITS'(since_trigger) <= AGE_BITS'(dead_span_reg);

    // The output register can take a new result when empty or being drained.
    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next         = state_reg;
        stamp_next         = stamp_reg;
        ooo_next           = ooo_reg;
        prev_next          = prev_reg;
        last_trig_next     = last_trig_reg;
        dead_next          = dead_reg;
        window_length_next = window_length_reg;
        min_hits_next      = min_hits_reg;
        dead_span_next     = dead_span_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        kind_next          = kind_reg;
        twice_next         = twice_reg;
        hits_next          = hits_reg;
        ctrl               = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: window_length_next = cfg_data;
                REG_MIN_HITS:      min_hits_next      = cfg_data[MIN_HITS_BITS-1:0];
                REG_DEAD_SPAN:     dead_span_next     = cfg_data;
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    stamp_next = hit_time;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                ctrl.eval  = 1'b1;
                ooo_next   = stamp_reg < prev_reg;
                state_next = S_DECIDE;
                if (stamp_reg >= prev_reg)
                begin
                    prev_next = stamp_reg;
                    if (dead_reg)
                    begin
                        if (in_dead_span)
                        begin
                            // Hit falls in the dead time: no result at all.
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            dead_next = 1'b0;
                        end
                    end
                end
            end

            S_DECIDE:
            begin
                if (ooo_reg)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_DROPPED;
                        twice_next     = '0;
                        hits_next      = '0;
                        state_next     = S_IDLE;
                    end
                end
                else if (fire)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_TRIGGER;
                        twice_next     = TWICE_BITS'(oldest) + TWICE_BITS'(stamp_reg);
                        hits_next      = HITS_BITS'(used);
                        ctrl.clear     = 1'b1;
                        last_trig_next = stamp_reg;
                        dead_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // No trigger: expired entries fall off the end and the
                    // hit joins the window at cell 0.
                    ctrl.shift = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ooo_reg           <= 1'b0;
            prev_reg          <= '0;
            last_trig_reg     <= '0;
            dead_reg          <= 1'b0;
            window_length_reg <= CFG_BITS'(100);
            min_hits_reg      <= MIN_HITS_BITS'(2);
            dead_span_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            ooo_reg           <= ooo_next;
            prev_reg          <= prev_next;
            last_trig_reg     <= last_trig_next;
            dead_reg          <= dead_next;
            window_length_reg <= window_length_next;
            min_hits_reg      <= min_hits_next;
            dead_span_reg     <= dead_span_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        kind_reg  <= kind_next;
        twice_reg <= twice_next;
        hits_reg  <= hits_next;
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign out_valid          = out_valid_reg;
    assign result_kind        = kind_reg;
    assign trigger_time_twice = twice_reg;
    assign hits_used          = hits_reg;

endmodule

`default_nettype wire

FILE: design/swtct_checker.sv
// Port-level checks for the trigger unit, attached by the bind at the end.
// Depends on swtct_pkg and the top-level port list.
`default_nettype none

module swtct_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_valid,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic                                 result_kind,
    input wire logic [swtct_pkg::TWICE_BITS-1:0]     trigger_time_twice,
    input wire logic [swtct_pkg::HITS_BITS-1:0]      hits_used
);
    import swtct_pkg::*;

    // A result that is not taken keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(trigger_time_twice) && $stable(hits_used))
        else $error("stalled result changed");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in flight");

    // A fresh result always traces back to an accepted item, through its judge and decide steps.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result without a matching item");

    // A dropped hit reports zeros; a trigger uses at least one hit.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_DROPPED |-> trigger_time_twice == '0
            && hits_used == '0)
        else $error("dropped hit carries trigger data");

    a_trig_hits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_TRIGGER |-> hits_used != '0)
        else $error("trigger with no hits");

endmodule

bind sliding_window_time_cluster_trigger_unit swtct_checker u_swtct_checker (.*);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the sliding window time cluster trigger unit.
// Depends on design/swtct_pkg.sv and design/sliding_window_time_cluster_trigger_unit.sv.
`timescale 1ns / 1ps

module testbench;
    import swtct_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 500000;
    // A hit that causes no trigger may still be in flight when the last
    // awaited result has arrived.
    localparam int SETTLE_CYCLES = 12;
    localparam int PRINT_LIMIT   = 100;
    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam longint unsigned STAMP_MAX = (64'd1 << TIME_BITS) - 64'd1;

    typedef struct packed {
        logic                    kind;
        logic [TWICE_BITS-1:0]   twice;
        logic [HITS_BITS-1:0]    hits;
    } trigger_rec_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    stamp_t hit_time;
    logic out_valid;
    logic out_ready;
    logic result_kind;
    logic [TWICE_BITS-1:0] trigger_time_twice;
    logic [HITS_BITS-1:0] hits_used;
    logic cfg_we;
    logic [REG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    sliding_window_time_cluster_trigger_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .hit_time           (hit_time),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result_kind        (result_kind),
        .trigger_time_twice (trigger_time_twice),
        .hits_used          (hits_used),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Hits waiting to be offered, and triggers the unit is expected to emit.
    stamp_t       hit_backlog[$];
    trigger_rec_t trigger_forecast[$];
    trigger_rec_t awaited;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int          failures        = 0;
    int          cycle_count     = 0;
    logic        hit_taken       = 1'b0;
    longint unsigned gen_stamp   = 0;

    // Shadow of the unit's registers and cluster state.
    logic [31:0]        span_cfg      = 32'd100;
    logic [6:0]         need_cfg      = 7'd2;
    logic [31:0]        dead_cfg      = 32'd0;
    stamp_t             ring_stamp [WINDOW_DEPTH];
    int                 ring_first    = 0;
    int                 ring_fill     = 0;
    stamp_t             last_fire     = '0;
    stamp_t             last_hit      = '0;
    logic               dead_active   = 1'b0;

    // Hits needed to fire: zero behaves as one, and anything beyond the
    // window depth saturates to the depth.
    function automatic int cluster_need();
        int n;
        n = int'(need_cfg);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > WINDOW_DEPTH)
        begin
            n = WINDOW_DEPTH;
        end
        return n;
    endfunction

    // Advances the shadow state by one accepted hit and queues the trigger
    // it causes, if any.
    task automatic forecast_trigger(input stamp_t t);
        trigger_rec_t rec;
        stamp_t       oldest;
        if (t < last_hit)
        begin
            // An out-of-order hit leaves every piece of state untouched.
            rec.kind  = KIND_DROPPED;
            rec.twice = '0;
            rec.hits  = '0;
            trigger_forecast.insert(trigger_forecast.size(), rec);
            return;
        end
        last_hit = t;
        if (dead_active)
        begin
            if ((t - last_fire) <= dead_cfg)
            begin
                return;
            end
            dead_active = 1'b0;
        end
        // Retire entries that are too old; a zero age never is.
        while (ring_fill > 0 && (t - ring_stamp[ring_first]) > span_cfg)
        begin
            ring_first = (ring_first + 1) % WINDOW_DEPTH;
            ring_fill--;
        end
        if (ring_fill + 1 >= cluster_need())
        begin
            oldest     = (ring_fill > 0) ? ring_stamp[ring_first] : t;
            rec.kind   = KIND_TRIGGER;
            rec.twice  = {1'b0, oldest} + {1'b0, t};
            rec.hits   = HITS_BITS'(ring_fill + 1);
            trigger_forecast.insert(trigger_forecast.size(), rec);
            ring_first  = 0;
            ring_fill   = 0;
            last_fire   = t;
            dead_active = 1'b1;
        end
        else
        begin
            ring_stamp[(ring_first + ring_fill) % WINDOW_DEPTH] = t;
            ring_fill++;
        end
    endtask

    task automatic report_field(input string name, input longint unsigned want,
                                input longint unsigned got);
        failures++;
        if (failures <= PRINT_LIMIT)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Driver: a new hit is offered only once the previous one was taken, so
    // valid and the payload hold steady while the unit stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || hit_taken)
            begin
                if (hit_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    hit_time <= hit_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: results are checked against the oldest forecast; accepted
    // hits feed the shadow model. A result can never come out in the same
    // cycle as the hit that caused it, so the order of the two is free.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (trigger_forecast.size() == 0)
                begin
                    failures++;
                    if (failures <= PRINT_LIMIT)
                    begin
                        $display("%0t ns: result with none expected, kind %0d time %0h hits %0d",
                                 $time, result_kind, trigger_time_twice, hits_used);
                    end
                end
                else
                begin
                    awaited = trigger_forecast.pop_front();
                    if (result_kind !== awaited.kind)
                    begin
                        report_field("result_kind", awaited.kind, result_kind);
                    end
                    if (trigger_time_twice !== awaited.twice)
                    begin
                        report_field("trigger_time_twice", awaited.twice, trigger_time_twice);
                    end
                    if (hits_used !== awaited.hits)
                    begin
                        report_field("hits_used", awaited.hits, hits_used);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                forecast_trigger(hit_time);
            end
            hit_taken <= in_valid && in_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Register writes happen only while the unit is idle, so the shadow copy
    // can be updated right away.
    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_LENGTH: span_cfg = value;
            REG_MIN_HITS:      need_cfg = value[MIN_HITS_BITS-1:0];
            REG_DEAD_SPAN:     dead_cfg = value;
            default:           ;
        endcase
    endtask

    task automatic push_hit(input longint unsigned t);
        hit_backlog.insert(hit_backlog.size(), stamp_t'(t));
        if (t > gen_stamp)
        begin
            gen_stamp = t;
        end
    endtask

    // Moves the stream clock forward, pinned at the largest stamp.
    task automatic advance(input longint unsigned delta);
        if (delta > STAMP_MAX - gen_stamp)
        begin
            gen_stamp = STAMP_MAX;
        end
        else
        begin
            gen_stamp = gen_stamp + delta;
        end
    endtask

    // Random stream shaped as clusters: bursts sized around the threshold
    // and packed tight enough to fit the window, separated by gaps that
    // either clear the dead time, age the window out, stay short, or jump far ahead.
    // A few stale hits are mixed in as noise.
    task automatic make_stream(input int count);
        int              made;
        int              burst;
        int              need;
        longint unsigned intra_max;
        longint unsigned back;
        made = 0;
        while (made < count)
        begin
            need      = cluster_need();
            burst     = $urandom_range(need + 1, 1);
            if (burst > count - made)
            begin
                burst = count - made;
            end
            intra_max = span_cfg / need;
            if (intra_max > 1000)
            begin
                intra_max = 1000;
            end
            repeat (burst)
            begin
                if ($urandom_range(99) < 3 && gen_stamp > 0)
                begin
                    back = (gen_stamp < 1000) ? gen_stamp : 1000;
                    hit_backlog.insert(hit_backlog.size(),
                                       stamp_t'(gen_stamp - $urandom_range(back, 1)));
                end
                else
                begin
                    advance($urandom_range(intra_max + intra_max / 2, 0));
                    hit_backlog.insert(hit_backlog.size(), stamp_t'(gen_stamp));
                end
                made++;
            end
            case ($urandom_range(3))
                0:       advance(longint'(dead_cfg) + $urandom_range(20, 1));
                1:       advance(longint'(span_cfg) + $urandom_range(20, 1));
                2:       advance($urandom_range(300, 0));
                default: advance($urandom);
            endcase
        end
    endtask

    // Waits until every hit has gone in and every forecast has come out,
    // then lets the pipeline settle.
    task automatic wait_drained();
        while (hit_backlog.size() != 0 || in_valid || trigger_forecast.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int unsigned idle_pct,
                             input int unsigned stall_pct);
        @(posedge clk);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        make_stream(count);
        wait_drained();
    endtask

    initial
    begin
        longint unsigned base;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        hit_time  = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_WINDOW_LENGTH;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: equal stamps, dead time of zero, a hit exactly at
        // the window edge, one just past it, and an out-of-order hit.
        @(posedge clk);
        push_hit(0);
        push_hit(0);
        push_hit(0);
        push_hit(1);
        push_hit(101);
        push_hit(50);
        push_hit(102);
        push_hit(203);
        push_hit(203);
        wait_drained();

        // Threshold zero fires on every hit outside the dead time; a zero window and a short dead
        // time; the unused register index must be ignored.
        write_reg(REG_WINDOW_LENGTH, 32'd0);
        write_reg(REG_MIN_HITS, 32'd0);
        write_reg(REG_DEAD_SPAN, 32'd5);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        @(posedge clk);
        base = gen_stamp + 1000;
        push_hit(base);
        push_hit(base);
        push_hit(base + 5);
        push_hit(base + 6);
        push_hit(base + 6);
        push_hit(base + 20);
        wait_drained();
        run_phase(60, 0, 0);

        // Threshold above the depth saturates, so full 64-hit clusters are
        // needed; the widest window keeps them together. Sender mostly idle.
        write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_MIN_HITS, 32'd127);
        write_reg(REG_DEAD_SPAN, 32'd0);
        run_phase(150, 87, 0);

        // Upper bits of the threshold write are masked off; the widest dead
        // time. Receiver mostly stalled.
        write_reg(REG_WINDOW_LENGTH, 32'd100);
        write_reg(REG_MIN_HITS, 32'hFFFF_FF83);
        write_reg(REG_DEAD_SPAN, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h0000_0000);
        run_phase(150, 0, 87);

        // Light idling on both sides. Between the two halves the sender
        // holds off until every forecast trigger has come back.
        write_reg(REG_WINDOW_LENGTH, 32'd1000);
        write_reg(REG_MIN_HITS, 32'd5);
        write_reg(REG_DEAD_SPAN, 32'd200);
        run_phase(80, 6, 6);
        run_phase(80, 6, 6);

        repeat (3)
        begin
            write_reg(REG_WINDOW_LENGTH,
                      ($urandom_range(1) == 1) ? $urandom : $urandom_range(2000, 0));
            write_reg(REG_MIN_HITS, $urandom);
            write_reg(REG_DEAD_SPAN, $urandom_range(500, 0));
            run_phase(50, 0, 0);
        end

        // Top of the stamp range: the largest trigger sum, then a stale hit.
        write_reg(REG_WINDOW_LENGTH, 32'd10);
        write_reg(REG_MIN_HITS, 32'd2);
        write_reg(REG_DEAD_SPAN, 32'd0);
        @(posedge clk);
        push_hit(STAMP_MAX - 5000);
        push_hit(STAMP_MAX - 4995);
        push_hit(STAMP_MAX);
        push_hit(STAMP_MAX);
        push_hit(0);
        wait_drained();

        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
